/* hdl/sorted_key_set_assert.svh */
// ----------------------------------------------------------------------------
// sorted_key_set_assert: assertion macros used by sks_checker, one of the hdl files
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_ASSERT_SVH
`define SORTED_KEY_SET_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SKS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define SKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sks_pkg.sv */
// ----------------------------------------------------------------------------
// sks_pkg
// Types, sizes and codes shared by the sorted key set block.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 48;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // item field widths
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 48;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // request modes; any other code is a lookup
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic probe;
        logic compare;
        logic ptr_init_up;
        logic ptr_init_dn;
        logic rd_prev;
        logic rd_next;
        logic wr_up;
        logic wr_dn;
        logic wr_key;
        logic dec_count;
        logic result;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic srch_more;
        logic is_add;
        logic is_rm;
        logic hit;
        logic full;
        logic up_more;
        logic dn_more;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* hdl/sks_ram.sv */
// ----------------------------------------------------------------------------
// sks_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/sks_dpath.sv */
// ----------------------------------------------------------------------------
// sks_dpath
// Search bounds, shift pointer, entry count, key store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sks_pkg::t_cmd      i_cmd,
    output sks_pkg::t_stat          o_stat,
    input  wire sks_pkg::t_in_item  i_in_item,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output sks_pkg::t_out_item      o_out_item
);

    import sks_pkg::*;

    logic [MODE_W-1:0]   r_mode;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [IDX_W-1:0]    r_mid;
    logic                r_hit;
    logic                r_ins;
    logic [CNT_W-1:0]    r_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [CNT_W-1:0]    w_mid;
    logic [CNT_W-1:0]    w_ptr_m1;
    logic [CNT_W-1:0]    w_ptr_p1;
    logic [KEY_BITS-1:0] w_rdata;
    logic                w_re;
    logic [IDX_W-1:0]    w_raddr;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [KEY_BITS-1:0] w_wdata;
    logic                w_is_add;
    logic                w_is_rm;
    t_out_item           w_res;

    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_ptr_m1 = r_ptr - CNT_W'(1);
    assign w_ptr_p1 = r_ptr + CNT_W'(1);
    assign w_is_add = (r_mode == MODE_ADD);
    assign w_is_rm  = (r_mode == MODE_REMOVE);

    always_comb begin
        w_re    = i_cmd.probe | i_cmd.rd_prev | i_cmd.rd_next;
        w_raddr = w_mid[IDX_W-1:0];
        if (i_cmd.rd_prev) begin
            w_raddr = w_ptr_m1[IDX_W-1:0];
        end else if (i_cmd.rd_next) begin
            w_raddr = w_ptr_p1[IDX_W-1:0];
        end
        w_we    = i_cmd.wr_up | i_cmd.wr_dn | i_cmd.wr_key;
        w_waddr = i_cmd.wr_key ? r_lo[IDX_W-1:0] : r_ptr[IDX_W-1:0];
        w_wdata = i_cmd.wr_key ? r_key : w_rdata;
    end

    sks_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // search and shift registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in_item.mode;
            r_key  <= KEY_BITS'(i_in_item.key);
            r_lo   <= '0;
            r_hi   <= r_count;
            r_hit  <= 1'b0;
            r_ins  <= 1'b0;
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid[IDX_W-1:0];
        end
        if (i_cmd.compare) begin
            if (w_rdata < r_key) begin
                r_lo <= CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                r_hi <= CNT_W'(r_mid);
            end
            // keys are unique, so an equal probe is the lower bound
            if (w_rdata == r_key) begin
                r_hit <= 1'b1;
            end
        end
        if (i_cmd.ptr_init_up) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_init_dn) begin
            r_ptr <= r_lo;
        end else if (i_cmd.wr_up) begin
            r_ptr <= w_ptr_m1;
        end else if (i_cmd.wr_dn) begin
            r_ptr <= w_ptr_p1;
        end
        if (i_cmd.wr_key) begin
            r_ins <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.wr_key) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec_count) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_comb begin
        w_res.found    = r_hit;
        w_res.count    = COUNT_W'(r_count);
        w_res.status   = ST_MISS;
        w_res.position = '0;
        if (r_hit) begin
            w_res.status   = w_is_add ? ST_DUP : ST_OK;
            w_res.position = POS_W'(r_lo);
        end else if (w_is_add) begin
            if (r_ins) begin
                w_res.status   = ST_OK;
                w_res.position = POS_W'(r_lo);
            end else begin
                w_res.status = ST_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_out <= w_res;
        end
    end

    always_comb begin
        o_stat.srch_more = (r_lo < r_hi);
        o_stat.is_add    = w_is_add;
        o_stat.is_rm     = w_is_rm;
        o_stat.hit       = r_hit;
        o_stat.full      = (r_count == CNT_W'(CAPACITY));
        o_stat.up_more   = (r_ptr > r_lo);
        o_stat.dn_more   = (w_ptr_p1 < r_count);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* hdl/sks_ctrl.sv */
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer: binary search over the store, then for an add or remove a shift up or down, then result.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire sks_pkg::t_stat i_stat,
    output sks_pkg::t_cmd       o_cmd
);

    import sks_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SRCH  = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_UP_RD = 8'b0000_1000,
        S_UP_WR = 8'b0001_0000,
        S_DN_RD = 8'b0010_0000,
        S_DN_WR = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_stat.srch_more) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end else if (i_stat.is_add && !i_stat.hit && !i_stat.full) begin
                    o_cmd.ptr_init_up = 1'b1;
                    n_state           = S_UP_RD;
                end else if (i_stat.is_rm && i_stat.hit) begin
                    o_cmd.ptr_init_dn = 1'b1;
                    n_state           = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_SRCH;
            end
            S_UP_RD: begin
                if (i_stat.up_more) begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_UP_WR;
                end else begin
                    o_cmd.wr_key = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_UP_WR: begin
                o_cmd.wr_up = 1'b1;
                n_state     = S_UP_RD;
            end
            S_DN_RD: begin
                if (i_stat.dn_more) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_DN_WR;
                end else begin
                    o_cmd.dec_count = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DN_WR: begin
                o_cmd.wr_dn = 1'b1;
                n_state     = S_DN_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* hdl/sorted_key_set.sv */
// ----------------------------------------------------------------------------
// sorted_key_set
// Set of unique keys held in ascending order in a RAM; lookup, add, remove.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  request  in   i_in_valid/o_in_stall  i_in_item  (mode, key)
//  result   out  o_out_valid/i_out_stall o_out_item (status, found, position, count)
//
//  One request at a time. Every store read goes through the single read
//  port of the key RAM, and each read is followed by a compare or a write.
//  A request makes P <= log2(CAPACITY)+1 search probes; an add or remove that
//  succeeds then moves M entries (M < CAPACITY), each by a read and a write.
//  Reset clears the entry count, the sequencer and the result valid; key RAM
//  contents are not cleared. A stalled result stays in its register while the
//  next request is taken.
//
`default_nettype none

module sorted_key_set (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sks_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sks_pkg::t_out_item      o_out_item
);

    import sks_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sks_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

/* hdl/sks_checker.sv */
// ----------------------------------------------------------------------------
// sks_checker
// Port-level checks on the sorted key set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_set_assert.svh"

module sks_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire sks_pkg::t_out_item o_out_item
);

    import sks_pkg::*;

    logic w_in_take;

    assign w_in_take = i_in_valid && !o_in_stall;

    // one request in flight: the port closes right after a take
    `SKS_ASSERT_NEXT(a_one_in_flight, w_in_take, o_in_stall, "request port open while busy")

    `SKS_ASSERT_NOW(a_count_range, o_out_valid, o_out_item.count <= COUNT_W'(CAPACITY),
        "count above capacity")

    `SKS_ASSERT_NOW(a_full_count, o_out_valid && (o_out_item.status == ST_FULL),
        o_out_item.count == COUNT_W'(CAPACITY) && !o_out_item.found,
        "full reported below capacity")

    `SKS_ASSERT_NOW(a_miss_pos,
        o_out_valid && !o_out_item.found && (o_out_item.status != ST_OK),
        o_out_item.position == '0, "nonzero position on miss")

    `SKS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item), "stalled result changed")

endmodule

bind sorted_key_set sks_checker u_sks_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: sorted_key_set
// Drives lookup, add and remove requests through the valid/stall request
// channel, with random idle bursts on both sides. A behavioral copy of the
// sorted store predicts every result, and each result is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import sks_pkg::*;

    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;   // unused code, acts as lookup
    localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};
    localparam int POOL_SIZE   = 96;
    localparam int ROUNDS      = 17;
    localparam int ROUND_ITEMS = 100;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1_200_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // predicted store contents
    logic [KEY_W-1:0] model_keys [CAPACITY];
    int               model_count = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    t_out_item        pending_results [$];
    bit               idle_on      = 1'b0;
    int unsigned      mismatches   = 0;
    int unsigned      cycle_count  = 0;
    int unsigned      out_hold     = 0;

    sorted_key_set uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // Applies one request to the predicted store and returns its result.
    function automatic t_out_item predict_result(input t_in_item req);
        t_out_item res;
        int        at;
        int        i;
        logic      hit;
        at = 0;
        while (at < model_count && model_keys[at] < req.key)
            at++;
        hit = (at < model_count) && (model_keys[at] == req.key);
        res = '0;
        res.found = hit;
        if (req.mode == MODE_ADD) begin
            if (hit) begin
                res.status   = ST_DUP;
                res.position = POS_W'(at);
            end else if (model_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                for (i = model_count; i > at; i--)
                    model_keys[i] = model_keys[i - 1];
                model_keys[at] = req.key;
                model_count++;
                res.status   = ST_OK;
                res.position = POS_W'(at);
            end
        end else if (req.mode == MODE_REMOVE) begin
            if (hit) begin
                for (i = at; i + 1 < model_count; i++)
                    model_keys[i] = model_keys[i + 1];
                model_count--;
                res.status   = ST_OK;
                res.position = POS_W'(at);
            end else begin
                res.status = ST_MISS;
            end
        end else begin
            res.status = hit ? ST_OK : ST_MISS;
            if (hit)
                res.position = POS_W'(at);
        end
        res.count = COUNT_W'(model_count);
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[KEY_W-1:0];
    endfunction

    // Mostly keys already stored or from the shared pool, so requests hit.
    function automatic logic [KEY_W-1:0] pick_key(input int stored_pct);
        if (model_count > 0 && $urandom_range(0, 99) < stored_pct)
            return model_keys[$urandom_range(0, model_count - 1)];
        if ($urandom_range(0, 9) == 0)
            return rand_key();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so back-to-back items keep it up.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [KEY_W-1:0] key);
        t_in_item req;
        req.mode = mode;
        req.key  = key;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(predict_result(req));
        @(negedge i_clk);
    endtask

    // result stall in random bursts
    always @(negedge i_clk) begin
        if (out_hold > 0)
            out_hold--;
        else if (idle_on && $urandom_range(0, 7) == 0)
            out_hold = $urandom_range(1, 15);
        i_out_stall <= (out_hold > 0);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result item with no request pending");
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status || o_out_item.found !== want.found ||
                    o_out_item.position !== want.position ||
                    o_out_item.count !== want.count)
                    note_mismatch($sformatf({"mismatch: want status %0d found %0d pos %0d ",
                        "count %0d, got status %0d found %0d pos %0d count %0d"},
                        want.status, want.found, want.position, want.count,
                        o_out_item.status, o_out_item.found, o_out_item.position,
                        o_out_item.count));
            end
        end
    end

    // extremes of the key, every mode, hits and misses, empty store
    task automatic test_directed();
        idle_on = 1'b0;
        send_request(MODE_LOOKUP, '0);
        send_request(MODE_REMOVE, KEY_MAX);
        send_request(MODE_SPARE, '0);
        send_request(MODE_ADD, 48'h8000_0000_0000);
        send_request(MODE_ADD, '0);
        send_request(MODE_ADD, KEY_MAX);
        send_request(MODE_ADD, 48'h1);
        send_request(MODE_ADD, KEY_MAX - 1);
        send_request(MODE_ADD, '0);
        send_request(MODE_ADD, KEY_MAX);
        send_request(MODE_LOOKUP, '0);
        send_request(MODE_LOOKUP, KEY_MAX);
        send_request(MODE_LOOKUP, 48'h2);
        send_request(MODE_SPARE, KEY_MAX - 1);
        send_request(MODE_SPARE, 48'h5555_5555_5555);
        send_request(MODE_ADD, 48'h7FFF_FFFF_FFFF);
        send_request(MODE_REMOVE, 48'h8000_0000_0000);
        send_request(MODE_REMOVE, 48'h8000_0000_0000);
        send_request(MODE_REMOVE, '0);
        send_request(MODE_REMOVE, KEY_MAX);
        send_request(MODE_LOOKUP, 48'h1);
        send_request(MODE_REMOVE, 48'h1);
        send_request(MODE_REMOVE, 48'h7FFF_FFFF_FFFF);
        send_request(MODE_REMOVE, KEY_MAX - 1);
        send_request(MODE_LOOKUP, KEY_MAX - 1);
    endtask

    // fill to capacity, push against the full store, then drain to empty
    task automatic test_fill_to_capacity();
        idle_on = 1'b1;
        while (model_count < CAPACITY)
            send_request(MODE_ADD, rand_key());
        repeat (3) send_request(MODE_ADD, rand_key());
        send_request(MODE_ADD, model_keys[$urandom_range(0, CAPACITY - 1)]);
        send_request(MODE_LOOKUP, model_keys[0]);
        send_request(MODE_LOOKUP, model_keys[CAPACITY - 1]);
        // smallest key in and out of a full store moves every other entry
        send_request(MODE_REMOVE, model_keys[0]);
        send_request(MODE_ADD, '0);
        send_request(MODE_ADD, KEY_MAX);
        send_request(MODE_REMOVE, model_keys[0]);
        send_request(MODE_ADD, KEY_MAX);
        while (model_count > 0)
            send_request(MODE_REMOVE, model_keys[$urandom_range(0, model_count - 1)]);
    endtask

    task automatic run_mixed_round(input int add_pct, input int rm_pct);
        int unsigned       roll;
        logic [MODE_W-1:0] mode;
        repeat (ROUND_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                mode = MODE_ADD;
            else if (roll < add_pct + rm_pct)
                mode = MODE_REMOVE;
            else if (roll < add_pct + rm_pct + 5)
                mode = MODE_SPARE;
            else
                mode = MODE_LOOKUP;
            send_request(mode, pick_key(mode == MODE_ADD ? 20 : 70));
        end
    endtask

    // rounds cycle through filling, balanced and draining traffic
    task automatic test_random_traffic();
        int r;
        for (r = 0; r < POOL_SIZE; r++) begin
            case (r % 8)
                0:       key_pool[r] = KEY_W'(r);
                1:       key_pool[r] = KEY_MAX - KEY_W'(r);
                2:       key_pool[r] = key_pool[r - 1] ^ 48'h1;
                default: key_pool[r] = rand_key();
            endcase
        end
        for (r = 0; r < ROUNDS; r++) begin
            idle_on = (r < ROUNDS - 2) && ($urandom_range(0, 3) != 0);
            case (r % 3)
                0:       run_mixed_round(65, 15);
                1:       run_mixed_round(35, 35);
                default: run_mixed_round(15, 65);
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_fill_to_capacity();
        test_random_traffic();
        i_in_valid <= 1'b0;
        idle_on = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_mismatch("results still expected at end of run");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
